/* sv/shd_pkg.sv */
// -----------------------------------------------------------------------------
// shd_pkg
// Shared types and constants for the sync-header packet deframer.
// -----------------------------------------------------------------------------
`default_nettype none

package shd_pkg;

   // Fixed field widths
   localparam int BYTE_BITS     = 8;
   localparam int CSR_DATA_BITS = 24;
   localparam int SLOT_BITS     = 3;
   localparam int HEADER_BYTES  = 4;

   // Register index of the magic byte register; table entries follow it
   localparam int CSR_MAGIC_INDEX = 0;

   // Result of a command id lookup
   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] slot;
   } lookup_type;

endpackage : shd_pkg

`default_nettype wire

/* sv/shd_req_if.sv */
// -----------------------------------------------------------------------------
// shd_req_if
// Receive byte channel: valid/ready handshake carrying one stream byte.
// -----------------------------------------------------------------------------
`default_nettype none

interface shd_req_if;
   import shd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface : shd_req_if

`default_nettype wire

/* sv/shd_rsp_if.sv */
// -----------------------------------------------------------------------------
// shd_rsp_if
// Packet byte channel: valid/ready handshake carrying one framed byte.
// -----------------------------------------------------------------------------
`default_nettype none

interface shd_rsp_if;
   import shd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 packet_start;
   logic                 packet_end;
   logic [SLOT_BITS-1:0] command_slot;

   modport source (output valid, output data_byte, output packet_start,
                   output packet_end, output command_slot, input ready);
   modport sink   (input valid, input data_byte, input packet_start,
                   input packet_end, input command_slot, output ready);

endinterface : shd_rsp_if

`default_nettype wire

/* sv/shd_cmd_table.sv */
// -----------------------------------------------------------------------------
// shd_cmd_table
// Command length table: holds the id/length entries and looks up an id,
// the highest-numbered matching entry winning.
// -----------------------------------------------------------------------------
`default_nettype none

module shd_cmd_table #(
   parameter  int TABLE_ENTRIES  = 5,
   parameter  int LENGTH_BITS    = 16,
   localparam int CSR_INDEX_BITS = $clog2(TABLE_ENTRIES + 1)
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire [CSR_INDEX_BITS-1:0]           csr_index,
   input  wire [shd_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   input  wire [shd_pkg::BYTE_BITS-1:0]       cmd_id,
   output shd_pkg::lookup_type                match,
   output logic [LENGTH_BITS-1:0]             match_len
);
   import shd_pkg::*;

   logic [BYTE_BITS-1:0]   id_ff  [TABLE_ENTRIES];
   logic [LENGTH_BITS-1:0] len_ff [TABLE_ENTRIES];

   // Write table entries; entry i sits at register index i + 1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            id_ff[i]  <= '0;
            len_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (csr_index == CSR_INDEX_BITS'(i + 1)) begin
               id_ff[i]  <= csr_wr_data[CSR_DATA_BITS-1 -: BYTE_BITS];
               len_ff[i] <= csr_wr_data[LENGTH_BITS-1:0];
            end
         end
      end
   end

   // Compare all ids at once; a later entry overrides an earlier one
   always_comb begin
      match     = '0;
      match_len = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (id_ff[i] == cmd_id) begin
            match.found = 1'b1;
            match.slot  = SLOT_BITS'(i);
            match_len   = len_ff[i];
         end
      end
   end

endmodule : shd_cmd_table

`default_nettype wire

/* sv/sync_header_packet_deframer.sv */
// A packet byte appears on rsp in the cycle after the byte that causes it.
// Throughput: while rsp is ready, one receive byte per cycle in the payload or
//   hunting; a matched header puts out up to four bytes, one a cycle through the
//   burst register, and the receive side waits until the last of them is taken.
// Reset: synchronous; clears the window, payload state, burst count and magic.
// -----------------------------------------------------------------------------
// sync_header_packet_deframer
// Hunts a byte stream for a four-byte sync header, looks up the packet length
// by command id and passes every packet byte on with start/end/slot marks.
// -----------------------------------------------------------------------------
`default_nettype none

module sync_header_packet_deframer #(
   parameter  int TABLE_ENTRIES  = 5,
   parameter  int LENGTH_BITS    = 16,
   localparam int CSR_INDEX_BITS = $clog2(TABLE_ENTRIES + 1)
) (
   input  wire                              clock,
   input  wire                              reset,
   shd_req_if.sink                          req_if,
   shd_rsp_if.source                        rsp_if,
   input  wire                              csr_wr_en,
   input  wire [CSR_INDEX_BITS-1:0]         csr_index,
   input  wire [shd_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import shd_pkg::*;

   localparam int BURST_BITS = $clog2(HEADER_BYTES + 1);
   localparam int IDX_BITS   = $clog2(HEADER_BYTES);

   // Configuration
   logic [CSR_DATA_BITS-1:0] magic_ff;

   // Hunt and payload state
   logic [3*BYTE_BITS-1:0]   window_bytes_ff, window_bytes_in;
   logic [1:0]               window_fill_ff, window_fill_in;
   logic                     in_payload_ff, in_payload_in;
   logic [LENGTH_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic [SLOT_BITS-1:0]     active_slot_ff, active_slot_in;

   // Burst register holding the results of one transaction
   logic [BYTE_BITS-1:0]     burst_ff [HEADER_BYTES];
   logic [BYTE_BITS-1:0]     burst_in [HEADER_BYTES];
   logic [BURST_BITS-1:0]    rem_ff, rem_in;
   logic [IDX_BITS-1:0]      idx_ff, idx_in;
   logic                     start_flag_ff, start_flag_in;
   logic                     end_flag_ff, end_flag_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [4*BYTE_BITS-1:0]   hdr;
   logic                     magic_ok;
   lookup_type               match;
   logic [LENGTH_BITS-1:0]   match_len;
   logic                     short_len;

   // Command table lookup on header byte 2 (newest byte held in the window)
   shd_cmd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_cmd_table (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd_id      (window_bytes_ff[BYTE_BITS-1:0]),
      .match       (match),
      .match_len   (match_len)
   );

   // Handshakes: take a new byte once the burst is empty or drains this cycle
   assign req_if.ready = (rem_ff == '0) ||
                         ((rem_ff == BURST_BITS'(1)) && rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_accept   = rsp_if.valid && rsp_if.ready;

   // Present the burst byte at the current position
   assign rsp_if.valid        = (rem_ff != '0);
   assign rsp_if.data_byte    = burst_ff[idx_ff];
   assign rsp_if.packet_start = start_flag_ff && (idx_ff == '0);
   assign rsp_if.packet_end   = end_flag_ff && (rem_ff == BURST_BITS'(1));
   assign rsp_if.command_slot = slot_ff;

   // Header compare: bytes 0, 1 and 3 against the magic register
   assign hdr       = {window_bytes_ff, req_if.rx_byte};
   assign magic_ok  = (hdr[31:24] == magic_ff[23:16]) &&
                      (hdr[23:16] == magic_ff[15:8]) &&
                      (hdr[7:0]   == magic_ff[7:0]);
   assign short_len = (match_len < LENGTH_BITS'(HEADER_BYTES));

   // Next state of the hunt, payload and burst registers
   always_comb begin
      window_bytes_in = window_bytes_ff;
      window_fill_in  = window_fill_ff;
      in_payload_in   = in_payload_ff;
      bytes_left_in   = bytes_left_ff;
      active_slot_in  = active_slot_ff;
      burst_in        = burst_ff;
      rem_in          = rem_ff;
      idx_in          = idx_ff;
      start_flag_in   = start_flag_ff;
      end_flag_in     = end_flag_ff;
      slot_in         = slot_ff;

      // advance the burst on each result transaction
      if (rsp_accept) begin
         rem_in = rem_ff - BURST_BITS'(1);
         idx_in = idx_ff + IDX_BITS'(1);
      end

      if (req_accept) begin
         priority if (in_payload_ff) begin
            // pass a payload byte straight through
            burst_in[0]   = req_if.rx_byte;
            rem_in        = BURST_BITS'(1);
            idx_in        = '0;
            start_flag_in = 1'b0;
            end_flag_in   = (bytes_left_ff <= LENGTH_BITS'(1));
            slot_in       = active_slot_ff;
            if (bytes_left_ff <= LENGTH_BITS'(1)) begin
               in_payload_in = 1'b0;
               bytes_left_in = '0;
            end else begin
               bytes_left_in = bytes_left_ff - LENGTH_BITS'(1);
            end
         end else if (window_fill_ff != 2'd3) begin
            // window not full: store only
            window_bytes_in = {window_bytes_ff[2*BYTE_BITS-1:0], req_if.rx_byte};
            window_fill_in  = window_fill_ff + 2'd1;
         end else if (!magic_ok) begin
            // slide the window by one byte
            window_bytes_in = hdr[3*BYTE_BITS-1:0];
         end else if (!match.found || (match_len == '0)) begin
            // drop the whole header
            window_bytes_in = '0;
            window_fill_in  = '0;
         end else begin
            // emit the header bytes of a recognized packet
            for (int i = 0; i < HEADER_BYTES; i++) begin
               burst_in[i] = hdr[4*BYTE_BITS-1-BYTE_BITS*i -: BYTE_BITS];
            end
            rem_in        = short_len ? BURST_BITS'(match_len[1:0])
                                      : BURST_BITS'(HEADER_BYTES);
            idx_in        = '0;
            start_flag_in = 1'b1;
            end_flag_in   = (match_len <= LENGTH_BITS'(HEADER_BYTES));
            slot_in       = match.slot;
            if (short_len) begin
               // keep the unsent header bytes for another search
               unique case (match_len[1:0])
                  2'd1: begin
                     window_bytes_in = hdr[3*BYTE_BITS-1:0];
                     window_fill_in  = 2'd3;
                  end
                  2'd2: begin
                     window_bytes_in = {{BYTE_BITS{1'b0}}, hdr[2*BYTE_BITS-1:0]};
                     window_fill_in  = 2'd2;
                  end
                  default: begin
                     window_bytes_in = {{2*BYTE_BITS{1'b0}}, hdr[BYTE_BITS-1:0]};
                     window_fill_in  = 2'd1;
                  end
               endcase
            end else begin
               window_bytes_in = '0;
               window_fill_in  = '0;
               if (match_len != LENGTH_BITS'(HEADER_BYTES)) begin
                  in_payload_in  = 1'b1;
                  bytes_left_in  = match_len - LENGTH_BITS'(HEADER_BYTES);
                  active_slot_in = match.slot;
               end
            end
         end
      end
   end

   // Hold control state and the magic register
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff        <= '0;
         window_bytes_ff <= '0;
         window_fill_ff  <= '0;
         in_payload_ff   <= 1'b0;
         bytes_left_ff   <= '0;
         active_slot_ff  <= '0;
         rem_ff          <= '0;
         idx_ff          <= '0;
         start_flag_ff   <= 1'b0;
         end_flag_ff     <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_INDEX_BITS'(CSR_MAGIC_INDEX))) begin
            magic_ff <= csr_wr_data;
         end
         window_bytes_ff <= window_bytes_in;
         window_fill_ff  <= window_fill_in;
         in_payload_ff   <= in_payload_in;
         bytes_left_ff   <= bytes_left_in;
         active_slot_ff  <= active_slot_in;
         rem_ff          <= rem_in;
         idx_ff          <= idx_in;
         start_flag_ff   <= start_flag_in;
         end_flag_ff     <= end_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
      slot_ff  <= slot_in;
   end

endmodule : sync_header_packet_deframer

`default_nettype wire

/* sv/shd_checker.sv */
// -----------------------------------------------------------------------------
// shd_checker
// Port-level checks for the sync-header packet deframer, bound to the top.
// -----------------------------------------------------------------------------
`default_nettype none

module shd_checker #(
   parameter int TABLE_ENTRIES = 5
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire [shd_pkg::BYTE_BITS-1:0]  rsp_data_byte,
   input wire [shd_pkg::SLOT_BITS-1:0]  rsp_command_slot
);
   import shd_pkg::*;

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // the receive side only waits while results are pending
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("receive stalled with no pending result");

   // a stalled result holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte))
      else $error("stalled result changed");

   // slot always names an existing table entry
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_command_slot} < (SLOT_BITS+1)'(TABLE_ENTRIES)))
      else $error("command slot out of range");

   // result valid is known after every receive transaction
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$isunknown(rsp_valid))
      else $error("result valid unknown after transaction");

endmodule : shd_checker

bind sync_header_packet_deframer shd_checker #(
   .TABLE_ENTRIES (TABLE_ENTRIES)
) u_shd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_data_byte    (rsp_if.data_byte),
   .rsp_command_slot (rsp_if.command_slot)
);

`default_nettype wire
